// ===== rtl/tsps_pkg.sv =====
// Shared types and constants for the temperature sensor poll sequencer.
`default_nettype none

package tsps_pkg;

   localparam int unsigned SENSOR_SLOTS_DEFAULT = 8;
   localparam int unsigned TIME_W   = 32;
   localparam int unsigned RAW_W    = 16;
   localparam int unsigned TEMP_W   = 14;
   localparam int unsigned IDX_W    = 3;
   localparam int unsigned ACTION_W = 2;
   localparam int unsigned CSR_IDX_W  = 4;
   localparam int unsigned CSR_DATA_W = 16;
   localparam int unsigned SAMPLE_W   = 16;
   localparam int unsigned MASK_W     = 8;
   localparam int unsigned RETRY_W    = 4;
   localparam int unsigned WAIT_W     = 16;
   localparam int unsigned INTERVAL_W = 26;

   localparam int unsigned MS_PER_SECOND  = 1000;
   localparam int unsigned CENTI_SCALE    = 100;
   localparam int unsigned RAW_FRAC_BITS  = 7;
   localparam int unsigned TEMP_LIMIT     = 120 * 100;
   localparam int unsigned RETRIES_RESET  = 3;
   localparam int unsigned WAIT_RESET     = 800;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SAMPLING   = 4'd0,
      CSR_ENABLE     = 4'd1,
      CSR_RETRIES    = 4'd2,
      CSR_CONV_WAIT  = 4'd3
   } csr_index_type;

   typedef enum logic [ACTION_W-1:0] {
      ACT_NONE    = 2'd0,
      ACT_REQUEST = 2'd1,
      ACT_READ    = 2'd2,
      ACT_PUBLISH = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_REQUEST = 3'd1,
      PH_WAIT    = 3'd2,
      PH_READ    = 3'd3,
      PH_PUBLISH = 3'd4
   } phase_type;

   typedef struct packed {
      logic              emit;
      logic              burst;
      action_type        action;
      logic [IDX_W-1:0]  index;
      logic [TEMP_W-1:0] temp;
   } rsp_desc_type;

   function automatic logic [TEMP_W-1:0] convert_raw(input logic [RAW_W-1:0] raw);
      logic [RAW_W+RAW_FRAC_BITS-1:0] prod;
      logic [RAW_W-1:0]               v;
      prod = {{RAW_FRAC_BITS{1'b0}}, raw} * (RAW_W + RAW_FRAC_BITS)'(CENTI_SCALE);
      v    = prod[RAW_W+RAW_FRAC_BITS-1:RAW_FRAC_BITS];
      if (raw[RAW_W-1] || (v >= RAW_W'(TEMP_LIMIT))) begin
         return '0;
      end
      return v[TEMP_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/tsps_ctrl.sv =====
// Poll sequencer control: registers, phase machine, reading store.
`default_nettype none

module tsps_ctrl #(
   parameter int unsigned SENSOR_SLOTS = tsps_pkg::SENSOR_SLOTS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_we,
   input  wire logic [tsps_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [tsps_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  wire logic                              step,
   input  wire logic [tsps_pkg::TIME_W-1:0]       now_ms,
   input  wire logic [tsps_pkg::RAW_W-1:0]        raw_temp,
   output tsps_pkg::rsp_desc_type                 desc,
   output logic [SENSOR_SLOTS-1:0][tsps_pkg::TEMP_W-1:0] store
);

   localparam int unsigned SIDX_W = (SENSOR_SLOTS > 1) ? $clog2(SENSOR_SLOTS) : 1;
   localparam int unsigned CNT_W  = $clog2(SENSOR_SLOTS + 1);

   logic [tsps_pkg::INTERVAL_W-1:0] interval_ff, interval_in;
   logic [tsps_pkg::MASK_W-1:0]     mask_ff, mask_in;
   logic [tsps_pkg::RETRY_W-1:0]    max_retries_ff, max_retries_in;
   logic [tsps_pkg::WAIT_W-1:0]     conv_wait_ff, conv_wait_in;

   tsps_pkg::phase_type             phase_ff, phase_in;
   logic [CNT_W-1:0]                slot_ff, slot_in;
   logic [tsps_pkg::TIME_W-1:0]     round_start_ff, round_start_in;
   logic [tsps_pkg::TIME_W-1:0]     request_time_ff, request_time_in;
   logic [SENSOR_SLOTS-1:0][tsps_pkg::TEMP_W-1:0] store_ff, store_in;
   logic                            error_ff, error_in;
   logic [tsps_pkg::RETRY_W-1:0]    retry_ff, retry_in;
   logic                            started_ff, started_in;

   logic [tsps_pkg::TIME_W-1:0]     interval32;
   logic [tsps_pkg::TEMP_W-1:0]     conv;
   logic [SIDX_W-1:0]               sidx;

   assign interval32 = tsps_pkg::TIME_W'(interval_ff);
   assign conv       = tsps_pkg::convert_raw(raw_temp);
   assign sidx       = slot_ff[SIDX_W-1:0];
   assign store      = store_ff;

   always_comb begin
      interval_in    = interval_ff;
      mask_in        = mask_ff;
      max_retries_in = max_retries_ff;
      conv_wait_in   = conv_wait_ff;
      if (csr_we) begin
         unique case (csr_index)
            tsps_pkg::CSR_SAMPLING: begin
               interval_in = tsps_pkg::INTERVAL_W'(csr_wdata) *
                             tsps_pkg::INTERVAL_W'(tsps_pkg::MS_PER_SECOND);
            end
            tsps_pkg::CSR_ENABLE:    mask_in = csr_wdata[tsps_pkg::MASK_W-1:0];
            tsps_pkg::CSR_RETRIES:   max_retries_in = csr_wdata[tsps_pkg::RETRY_W-1:0];
            tsps_pkg::CSR_CONV_WAIT: conv_wait_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      phase_in        = phase_ff;
      slot_in         = slot_ff;
      round_start_in  = round_start_ff;
      request_time_in = request_time_ff;
      store_in        = store_ff;
      error_in        = error_ff;
      retry_in        = retry_ff;
      started_in      = started_ff;
      desc            = '0;
      desc.action     = tsps_pkg::ACT_NONE;
      if (step && (interval_ff != '0)) begin
         desc.emit = 1'b1;
         if (!started_ff) begin
            started_in     = 1'b1;
            round_start_in = now_ms - interval32;
         end
         unique case (phase_ff)
            tsps_pkg::PH_IDLE: begin
               if (!started_ff || ((now_ms - round_start_ff) >= interval32)) begin
                  round_start_in = now_ms;
                  store_in       = '0;
                  phase_in       = tsps_pkg::PH_REQUEST;
                  retry_in       = '0;
               end
            end
            tsps_pkg::PH_REQUEST: begin
               request_time_in = now_ms;
               phase_in        = tsps_pkg::PH_WAIT;
               error_in        = 1'b0;
               desc.action     = tsps_pkg::ACT_REQUEST;
            end
            tsps_pkg::PH_WAIT: begin
               if ((now_ms - request_time_ff) >= tsps_pkg::TIME_W'(conv_wait_ff)) begin
                  phase_in = tsps_pkg::PH_READ;
                  slot_in  = '0;
               end
            end
            tsps_pkg::PH_READ: begin
               if (slot_ff >= CNT_W'(SENSOR_SLOTS)) begin
                  if (error_ff && (retry_ff < max_retries_ff)) begin
                     retry_in = retry_ff + 1'b1;
                     phase_in = tsps_pkg::PH_REQUEST;
                  end else begin
                     phase_in = tsps_pkg::PH_PUBLISH;
                  end
               end else begin
                  slot_in = slot_ff + 1'b1;
                  if (mask_ff[sidx] && (store_ff[sidx] == '0)) begin
                     store_in[sidx] = conv;
                     if (conv == '0) begin
                        error_in = 1'b1;
                     end
                     desc.action = tsps_pkg::ACT_READ;
                     desc.index  = tsps_pkg::IDX_W'(sidx);
                     desc.temp   = conv;
                  end
               end
            end
            tsps_pkg::PH_PUBLISH: begin
               desc.action = tsps_pkg::ACT_PUBLISH;
               desc.burst  = 1'b1;
               phase_in    = tsps_pkg::PH_IDLE;
            end
            default: phase_in = tsps_pkg::PH_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff     <= '0;
         mask_ff         <= '0;
         max_retries_ff  <= tsps_pkg::RETRY_W'(tsps_pkg::RETRIES_RESET);
         conv_wait_ff    <= tsps_pkg::WAIT_W'(tsps_pkg::WAIT_RESET);
         phase_ff        <= tsps_pkg::PH_IDLE;
         slot_ff         <= '0;
         round_start_ff  <= '0;
         request_time_ff <= '0;
         store_ff        <= '0;
         error_ff        <= 1'b0;
         retry_ff        <= '0;
         started_ff      <= 1'b0;
      end else begin
         interval_ff     <= interval_in;
         mask_ff         <= mask_in;
         max_retries_ff  <= max_retries_in;
         conv_wait_ff    <= conv_wait_in;
         phase_ff        <= phase_in;
         slot_ff         <= slot_in;
         round_start_ff  <= round_start_in;
         request_time_ff <= request_time_in;
         store_ff        <= store_in;
         error_ff        <= error_in;
         retry_ff        <= retry_in;
         started_ff      <= started_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/tsps_out.sv =====
// Result register: holds one word, steps through the slots on publish.
`default_nettype none

module tsps_out #(
   parameter int unsigned SENSOR_SLOTS = tsps_pkg::SENSOR_SLOTS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              load,
   input  wire tsps_pkg::rsp_desc_type            desc,
   input  wire logic [SENSOR_SLOTS-1:0][tsps_pkg::TEMP_W-1:0] store,
   output logic                                   free,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [tsps_pkg::ACTION_W-1:0]          rsp_action,
   output logic [tsps_pkg::IDX_W-1:0]             rsp_sensor_index,
   output logic [tsps_pkg::TEMP_W-1:0]            rsp_temperature_centi,
   output logic                                   rsp_last
);

   localparam int unsigned SIDX_W = (SENSOR_SLOTS > 1) ? $clog2(SENSOR_SLOTS) : 1;

   logic                          valid_ff, valid_in;
   tsps_pkg::action_type          action_ff, action_in;
   logic [tsps_pkg::IDX_W-1:0]    index_ff, index_in;
   logic [tsps_pkg::TEMP_W-1:0]   temp_ff, temp_in;
   logic                          last_ff, last_in;
   logic [SIDX_W-1:0]             next_idx;
   logic                          taken;

   assign taken    = valid_ff && rsp_ready;
   assign free     = !valid_ff || (rsp_ready && last_ff);
   assign next_idx = index_ff[SIDX_W-1:0] + 1'b1;

   always_comb begin
      valid_in  = valid_ff;
      action_in = action_ff;
      index_in  = index_ff;
      temp_in   = temp_ff;
      last_in   = last_ff;
      if (taken && !last_ff) begin
         // advance through the publish burst
         index_in = tsps_pkg::IDX_W'(next_idx);
         temp_in  = store[next_idx];
         last_in  = (next_idx == SIDX_W'(SENSOR_SLOTS - 1));
      end else if (free) begin
         valid_in  = load && desc.emit;
         action_in = desc.action;
         if (desc.burst) begin
            index_in = '0;
            temp_in  = store[0];
            last_in  = (SENSOR_SLOTS == 1);
         end else begin
            index_in = desc.index;
            temp_in  = desc.temp;
            last_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         last_ff  <= 1'b1;
      end else begin
         valid_ff <= valid_in;
         last_ff  <= last_in;
      end
      action_ff <= action_in;
      index_ff  <= index_in;
      temp_ff   <= temp_in;
   end

   assign rsp_valid             = valid_ff;
   assign rsp_action            = action_ff;
   assign rsp_sensor_index      = index_ff;
   assign rsp_temperature_centi = temp_ff;
   assign rsp_last              = last_ff;

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && (action_ff != tsps_pkg::ACT_PUBLISH)) |-> last_ff)
      else $error("non-publish word without last");

   a_burst_cont: assert property (@(posedge clock) disable iff (reset)
      (taken && !last_ff) |=> (valid_ff && (action_ff == tsps_pkg::ACT_PUBLISH)))
      else $error("publish burst broken");

   a_burst_index: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !last_ff) |-> (index_ff < tsps_pkg::IDX_W'(SENSOR_SLOTS - 1)))
      else $error("publish index out of range");

   a_free_rule: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !rsp_ready) |-> !free)
      else $error("new item taken while result stalled");

endmodule

`default_nettype wire

// ===== rtl/temp_sensor_poll_sequencer.sv =====
// Top level of the temperature sensor poll sequencer.
//
// Usage: each req_ word is one poll step with the current millisecond time
// and the raw 1/128 degree reading of the slot being addressed. Each step
// gives one rsp_ word (action none, request or read), a publish step gives
// SENSOR_SLOTS words, one per slot, with rsp_last on the final one. With
// sampling_seconds at 0 a step is taken and gives no word.
// Registers are written on the csr_ channel, which is always ready; write
// only while no step has words outstanding.
// The first result word is registered and shows in the cycle after the step is taken.
// Throughput: one step per cycle while rsp_ready is high; a publish step holds
// the result register for its SENSOR_SLOTS words, one word per cycle while
// rsp_ready is high, as the single result register steps through the reading store.
// Reset: registers return to their defaults, phase to idle, store cleared.
// Stall: while rsp_ready is low the shown word holds, and req_ready stays
// low until the last word of the current step is taken.
`default_nettype none

module temp_sensor_poll_sequencer #(
   parameter int unsigned SENSOR_SLOTS = tsps_pkg::SENSOR_SLOTS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [tsps_pkg::TIME_W-1:0]       req_now_ms,
   input  wire logic signed [tsps_pkg::RAW_W-1:0] req_raw_temp,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [tsps_pkg::ACTION_W-1:0]          rsp_action,
   output logic [tsps_pkg::IDX_W-1:0]             rsp_sensor_index,
   output logic [tsps_pkg::TEMP_W-1:0]            rsp_temperature_centi,
   output logic                                   rsp_last,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [tsps_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [tsps_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   tsps_pkg::rsp_desc_type                         desc;
   logic [SENSOR_SLOTS-1:0][tsps_pkg::TEMP_W-1:0]  store;
   logic                                           free;
   logic                                           step;

   assign csr_ready = 1'b1;
   assign req_ready = free;
   assign step      = req_valid && free;

   tsps_ctrl #(
      .SENSOR_SLOTS (SENSOR_SLOTS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .step      (step),
      .now_ms    (req_now_ms),
      .raw_temp  (req_raw_temp),
      .desc      (desc),
      .store     (store)
   );

   tsps_out #(
      .SENSOR_SLOTS (SENSOR_SLOTS)
   ) u_out (
      .clock                 (clock),
      .reset                 (reset),
      .load                  (step),
      .desc                  (desc),
      .store                 (store),
      .free                  (free),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_action            (rsp_action),
      .rsp_sensor_index      (rsp_sensor_index),
      .rsp_temperature_centi (rsp_temperature_centi),
      .rsp_last              (rsp_last)
   );

endmodule

`default_nettype wire

// ===== sim/tsps_poll_checker.sv =====
// Checker for the poll sequencer: predicts result words from accepted steps and compares them.
`timescale 1ns / 100ps

module tsps_poll_checker
   import tsps_pkg::*;
#(
   parameter int unsigned SLOTS = SENSOR_SLOTS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_ready,
   input  wire logic [TIME_W-1:0]     req_now_ms,
   input  wire logic [RAW_W-1:0]      req_raw_temp,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire logic [ACTION_W-1:0]   rsp_action,
   input  wire logic [IDX_W-1:0]      rsp_sensor_index,
   input  wire logic [TEMP_W-1:0]     rsp_temperature_centi,
   input  wire logic                  rsp_last,
   input  wire logic                  csr_valid,
   input  wire logic                  csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output int                         failures,
   output int                         words_due
);

   typedef struct packed {
      action_type        action;
      logic [IDX_W-1:0]  slot;
      logic [TEMP_W-1:0] centi;
      logic              last;
   } poll_word_type;

   poll_word_type pending_words[$];

   logic [SAMPLE_W-1:0] sampling_s;
   logic [MASK_W-1:0]   enables;
   logic [RETRY_W-1:0]  retry_limit;
   logic [WAIT_W-1:0]   conv_wait;

   phase_type           phase;
   logic [3:0]          slot;
   logic [TIME_W-1:0]   round_start;
   logic [TIME_W-1:0]   request_at;
   logic [TEMP_W-1:0]   store [SLOTS];
   logic                read_failed;
   logic [RETRY_W-1:0]  retries_used;
   logic                running;

   task automatic note_failure(string msg);
      if (failures < 30) begin
         $display("checker: %0t ns: %s", $time, msg);
      end
      failures = failures + 1;
   endtask

   task automatic clear_state();
      int i;
      sampling_s   = '0;
      enables      = '0;
      retry_limit  = RETRY_W'(RETRIES_RESET);
      conv_wait    = WAIT_W'(WAIT_RESET);
      phase        = PH_IDLE;
      slot         = '0;
      round_start  = '0;
      request_at   = '0;
      read_failed  = 1'b0;
      retries_used = '0;
      running      = 1'b0;
      for (i = 0; i < SLOTS; i++) begin
         store[i] = '0;
      end
      pending_words.delete();
   endtask

   task automatic write_setting(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_SAMPLING:  sampling_s  = data[SAMPLE_W-1:0];
         CSR_ENABLE:    enables     = data[MASK_W-1:0];
         CSR_RETRIES:   retry_limit = data[RETRY_W-1:0];
         CSR_CONV_WAIT: conv_wait   = data[WAIT_W-1:0];
         default: ;
      endcase
   endtask

   function automatic logic [TEMP_W-1:0] centi_of(logic [RAW_W-1:0] raw);
      logic [22:0] scaled;
      if (raw[RAW_W-1]) begin
         return '0;
      end
      scaled = 23'(raw) * 23'(CENTI_SCALE);
      scaled = scaled >> RAW_FRAC_BITS;
      if (scaled >= TEMP_LIMIT) begin
         return '0;
      end
      return scaled[TEMP_W-1:0];
   endfunction

   task automatic queue_word(action_type act, int s, logic [TEMP_W-1:0] c, logic l);
      poll_word_type w;
      w.action = act;
      w.slot   = IDX_W'(s);
      w.centi  = c;
      w.last   = l;
      pending_words.push_back(w);
   endtask

   task automatic advance_poll(logic [TIME_W-1:0] now, logic [RAW_W-1:0] raw);
      logic [TIME_W-1:0] interval;
      logic [TEMP_W-1:0] centi;
      int                s;
      int                i;
      if (sampling_s == '0) begin
         return;
      end
      interval = sampling_s * MS_PER_SECOND;
      if (!running) begin
         running     = 1'b1;
         round_start = now - interval;
      end
      case (phase)
         PH_IDLE: begin
            if (now - round_start >= interval) begin
               round_start = now;
               for (i = 0; i < SLOTS; i++) begin
                  store[i] = '0;
               end
               phase        = PH_REQUEST;
               retries_used = '0;
            end
            queue_word(ACT_NONE, 0, '0, 1'b1);
         end
         PH_REQUEST: begin
            request_at  = now;
            phase       = PH_WAIT;
            read_failed = 1'b0;
            queue_word(ACT_REQUEST, 0, '0, 1'b1);
         end
         PH_WAIT: begin
            if (now - request_at >= TIME_W'(conv_wait)) begin
               phase = PH_READ;
               slot  = '0;
            end
            queue_word(ACT_NONE, 0, '0, 1'b1);
         end
         PH_READ: begin
            if (slot >= SLOTS) begin
               if (read_failed && retries_used < retry_limit) begin
                  retries_used = retries_used + 1'b1;
                  phase        = PH_REQUEST;
               end else begin
                  phase = PH_PUBLISH;
               end
               queue_word(ACT_NONE, 0, '0, 1'b1);
            end else begin
               s    = slot;
               slot = slot + 1'b1;
               if (enables[s] && store[s] == '0) begin
                  centi    = centi_of(raw);
                  store[s] = centi;
                  if (centi == '0) begin
                     read_failed = 1'b1;
                  end
                  queue_word(ACT_READ, s, centi, 1'b1);
               end else begin
                  queue_word(ACT_NONE, 0, '0, 1'b1);
               end
            end
         end
         PH_PUBLISH: begin
            for (i = 0; i < SLOTS; i++) begin
               queue_word(ACT_PUBLISH, i, store[i], i == SLOTS - 1);
            end
            phase = PH_IDLE;
         end
         default: begin
            phase = PH_IDLE;
            queue_word(ACT_NONE, 0, '0, 1'b1);
         end
      endcase
   endtask

   task automatic check_word();
      poll_word_type want;
      if (pending_words.size() == 0) begin
         note_failure($sformatf("word with nothing due: action %0d slot %0d centi %0d",
                                rsp_action, rsp_sensor_index, rsp_temperature_centi));
         return;
      end
      want = pending_words.pop_front();
      if (rsp_action !== want.action) begin
         note_failure($sformatf("action got %0d want %0d", rsp_action, want.action));
      end
      if (rsp_sensor_index !== want.slot) begin
         note_failure($sformatf("sensor_index got %0d want %0d", rsp_sensor_index, want.slot));
      end
      if (rsp_temperature_centi !== want.centi) begin
         note_failure($sformatf("temperature_centi got %0d want %0d (slot %0d)",
                                rsp_temperature_centi, want.centi, want.slot));
      end
      if (rsp_last !== want.last) begin
         note_failure($sformatf("last got %0d want %0d", rsp_last, want.last));
      end
   endtask

   // sample at the falling edge, ahead of the rising edge that takes the word
   always @(negedge clock) begin
      if (reset) begin
         clear_state();
      end else begin
         if (csr_valid && csr_ready) begin
            write_setting(csr_index, csr_wdata);
         end
         if (rsp_valid && rsp_ready) begin
            check_word();
         end
         if (req_valid && req_ready) begin
            advance_poll(req_now_ms, req_raw_temp);
         end
      end
      words_due = pending_words.size();
   end

endmodule

// ===== sim/testbench.sv =====
// Top of the poll sequencer testbench: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 100ps

module testbench;

   import tsps_pkg::*;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic [TIME_W-1:0]            req_now_ms = '0;
   logic signed [RAW_W-1:0]      req_raw_temp = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic [ACTION_W-1:0]          rsp_action;
   logic [IDX_W-1:0]             rsp_sensor_index;
   logic [TEMP_W-1:0]            rsp_temperature_centi;
   logic                         rsp_last;
   logic                         csr_valid = 1'b0;
   logic                         csr_ready;
   logic [CSR_IDX_W-1:0]         csr_index = '0;
   logic [CSR_DATA_W-1:0]        csr_wdata = '0;

   int                           failures;
   int                           words_due;
   logic                         hold_ask = 1'b0;
   logic [TIME_W-1:0]            clock_ms;

   logic [RAW_W-1:0] corner_raw [24] = '{
      16'd0, 16'd0, 16'd0,
      16'h0000, 16'h8000, 16'h7FFF, 16'd15359, 16'd15360, 16'd1, 16'd2, 16'hFFFF,
      16'd0, 16'd0, 16'd0,
      16'd1280, 16'd128, 16'd12800, 16'd0, 16'd256, 16'd640, 16'd0, 16'd100,
      16'd0, 16'd0
   };

   temp_sensor_poll_sequencer dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_now_ms(req_now_ms),
      .req_raw_temp(req_raw_temp),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_action(rsp_action),
      .rsp_sensor_index(rsp_sensor_index),
      .rsp_temperature_centi(rsp_temperature_centi),
      .rsp_last(rsp_last),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   tsps_poll_checker watcher (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_now_ms(req_now_ms),
      .req_raw_temp(req_raw_temp),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_action(rsp_action),
      .rsp_sensor_index(rsp_sensor_index),
      .rsp_temperature_centi(rsp_temperature_centi),
      .rsp_last(rsp_last),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .failures(failures),
      .words_due(words_due)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      #3_000_000;
      $display("testbench: FAIL");
      $finish;
   end

   task automatic send_step(logic [TIME_W-1:0] now, logic [RAW_W-1:0] raw);
      req_valid    <= 1'b1;
      req_now_ms   <= now;
      req_raw_temp <= raw;
      @(negedge clock);
      while (!req_ready) begin
         @(negedge clock);
      end
      @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      while (!csr_ready) begin
         @(negedge clock);
      end
      @(posedge clock);
   endtask

   task automatic apply_settings(logic [SAMPLE_W-1:0] sampling, logic [MASK_W-1:0] mask,
                                 logic [RETRY_W-1:0] retries, logic [WAIT_W-1:0] conv_wait);
      write_reg(CSR_SAMPLING, sampling);
      write_reg(CSR_ENABLE, {8'($urandom), mask});
      write_reg(CSR_RETRIES, {12'($urandom), retries});
      write_reg(CSR_CONV_WAIT, conv_wait);
      if ($urandom_range(0, 2) == 0) begin
         write_reg(CSR_IDX_W'(CSR_CONV_WAIT) + CSR_IDX_W'($urandom_range(1, 12)), 16'($urandom));
      end
      csr_valid <= 1'b0;
   endtask

   // drop valid, drain every due word, then allow for a step that gives none
   task automatic settle();
      req_valid <= 1'b0;
      while (words_due != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [RAW_W-1:0] random_raw();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         return RAW_W'($urandom_range(1, 15359));
      end
      if (pick < 65) begin
         return '0;
      end
      if (pick < 80) begin
         return RAW_W'($urandom_range(32768, 65535));
      end
      return RAW_W'($urandom_range(15360, 32767));
   endfunction

   task automatic offer_random(int count, bit with_gaps);
      int burst;
      int gap;
      int pick;
      while (count > 0) begin
         burst = $urandom_range(1, 8);
         while (burst > 0 && count > 0) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
               clock_ms = clock_ms + $urandom_range(0, 300);
            end else if (pick < 92) begin
               clock_ms = clock_ms + $urandom_range(0, 70000000);
            end else begin
               clock_ms = $urandom;
            end
            send_step(clock_ms, random_raw());
            burst--;
            count--;
         end
         if (with_gaps && count > 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   endtask

   initial begin : receiver
      int  mode;
      int  stretch;
      int  k;
      bit  held;
      held = 1'b0;
      @(posedge clock);
      forever begin
         if (hold_ask && !held) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (400) @(posedge clock);
         end
         mode    = $urandom_range(0, 3);
         stretch = $urandom_range(5, 60);
         for (k = 0; k < stretch; k++) begin
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 3) != 0);
               2: rsp_ready <= (k % 3 == 0);
               default: rsp_ready <= 1'($urandom_range(0, 1));
            endcase
            @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      int p;
      int i;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      clock_ms = 32'h0000_1000;
      for (i = 0; i < 2; i++) begin
         clock_ms = clock_ms + 1;
         send_step(clock_ms, corner_raw[i + 3]);
      end
      settle();

      apply_settings(16'd1, 8'hFF, 4'd15, 16'd0);
      clock_ms = 32'hFFFF_FFF4;
      for (i = 0; i < 24; i++) begin
         clock_ms = clock_ms + 1;
         send_step(clock_ms, corner_raw[i]);
      end
      settle();

      for (p = 0; p < 9; p++) begin
         case (p)
            0: apply_settings(16'd1, 8'hFF, 4'd0, 16'd0);
            1: apply_settings(16'd1, 8'h5A, 4'd15, 16'd20);
            2: apply_settings(16'hFFFF, 8'h81, 4'd3, 16'hFFFF);
            3: apply_settings(16'd0, 8'($urandom), 4'($urandom), 16'($urandom));
            4: apply_settings(16'd2, 8'h00, 4'd2, 16'd800);
            default: apply_settings(16'($urandom_range(1, 4)), 8'($urandom), 4'($urandom),
                                    16'($urandom_range(0, 1500)));
         endcase
         if (p == 1) begin
            hold_ask <= 1'b1;
         end
         offer_random(p == 3 ? 10 : 40, p != 0);
         settle();
      end

      while (words_due != 0) begin
         @(posedge clock);
      end
      repeat (10) @(posedge clock);
      if (failures == 0 && words_due == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
